[sv/atrd_pkg.sv]
// Shared constants, codes and controller/datapath command types of the R-peak detector.
`default_nettype none
package atrd_pkg;

	localparam int unsigned INTERVAL_DEPTH_DEF = 16;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned LEVEL_W    = 32;
	localparam int unsigned RATE_W     = 13;
	localparam int unsigned REFR_W     = 16;
	localparam int unsigned WEIGHT_W   = 9;
	localparam int unsigned IV_W       = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// 60 s * 1000 ms: numerator per ring slot of the rate estimate
	localparam int unsigned MS_PER_MINUTE = 60000;

	localparam logic [REFR_W-1:0]   REFR_RESET   = 16'd200;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd192;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
	localparam logic [RATE_W-1:0]   RATE_MAX     = 13'd8191;
	localparam logic [IV_W-1:0]     IV_MAX       = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REFRACTORY = 1'b0,
		CFG_WEIGHT     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic level;
		logic mul;
		logic thr;
		logic div_start;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scored;
		logic hit;
		logic div_done;
	} dp_status_t;

endpackage
`default_nettype wire

[sv/atrd_ifs.sv]
// Valid/ready channel interfaces for sample input and detector result output.
`default_nettype none
interface atrd_in_if;
	logic                            valid;
	logic                            ready;
	logic [atrd_pkg::SAMPLE_W-1:0]   sample;
	logic [atrd_pkg::TICK_W-1:0]     tick_ms;

	modport source (output valid, sample, tick_ms, input ready);
	modport sink   (input valid, sample, tick_ms, output ready);
endinterface

interface atrd_out_if;
	logic                            valid;
	logic                            ready;
	logic                            peak_found;
	logic [atrd_pkg::RATE_W-1:0]     heart_rate;
	logic [atrd_pkg::LEVEL_W-1:0]    detect_threshold;
	logic [atrd_pkg::LEVEL_W-1:0]    signal_peak_level;
	logic [atrd_pkg::LEVEL_W-1:0]    noise_peak_level;

	modport source (output valid, peak_found, heart_rate, detect_threshold,
		signal_peak_level, noise_peak_level, input ready);
	modport sink   (input valid, peak_found, heart_rate, detect_threshold,
		signal_peak_level, noise_peak_level, output ready);
endinterface
`default_nettype wire

[sv/adaptive_threshold_rpeak_detector_core.sv]
// Adaptive-threshold R-peak detector top level: controller, datapath and ports.
// Takes one integrated ECG sample with its millisecond tick per input transfer and
// returns exactly one result transfer per sample. The middle of the last three samples
// is a local maximum when it is at least both neighbors; if refractory_ms ticks have
// passed since the last R peak it is scored: above the threshold it is an R peak (signal
// level moves 1/8 toward it, the interval goes into an INTERVAL_DEPTH-entry ring and
// the rate becomes floor(60000*INTERVAL_DEPTH / interval sum), capped at 8191), else
// the noise level moves 1/8 toward it; then threshold = noise + weight*(signal-noise)/256.
// Steps: an unscored sample passes the evaluate, level and output states; a noise peak
// also passes multiply and threshold, and an R peak then waits in the divide state for
// the bit-serial rate divider before the output state. One sample is in work at a time;
// input ready is high only between items, and a new sample can be taken while the
// previous result still waits in the output register. Write configuration only while
// no item is in work.
`default_nettype none
module adaptive_threshold_rpeak_detector_core #(
	parameter int unsigned INTERVAL_DEPTH = atrd_pkg::INTERVAL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	atrd_in_if.sink                              in_ch,
	atrd_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [atrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [atrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// command/status bundle between the sequencer and the datapath
	atrd_pkg::dp_cmd_t    cmd;
	atrd_pkg::dp_status_t status;

	// sequencer: walks evaluate, level, multiply, threshold, divide, output
	atrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: holds all detector state, the interval ring and the result register
	atrd_datapath #(
		.INTERVAL_DEPTH (INTERVAL_DEPTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_sample         (in_ch.sample),
		.in_tick_ms        (in_ch.tick_ms),
		.peak_found        (out_ch.peak_found),
		.heart_rate        (out_ch.heart_rate),
		.detect_threshold  (out_ch.detect_threshold),
		.signal_peak_level (out_ch.signal_peak_level),
		.noise_peak_level  (out_ch.noise_peak_level)
	);

endmodule
`default_nettype wire

[sv/atrd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atrd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output      logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/atrd_div.sv]
// Restoring divider, one quotient bit per cycle, for a constant numerator.
`default_nettype none
module atrd_div #(
	parameter int unsigned NUM_W     = 20,
	parameter int unsigned DEN_W     = 20,
	parameter int unsigned NUMERATOR = 960000
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DEN_W-1:0] divisor,
	output      logic             done,
	output      logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the numerator out of the quotient register as quotient bits come in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= NUM_W'(NUMERATOR);
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[sv/atrd_datapath.sv]
// Detector datapath: sample window, levels, threshold, interval ring and rate divider.
`default_nettype none
module atrd_datapath #(
	parameter int unsigned INTERVAL_DEPTH = atrd_pkg::INTERVAL_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire atrd_pkg::dp_cmd_t                   cmd,
	output      atrd_pkg::dp_status_t                status,
	input  wire logic                                cfg_we,
	input  wire logic [atrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [atrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic [atrd_pkg::SAMPLE_W-1:0]       in_sample,
	input  wire logic [atrd_pkg::TICK_W-1:0]         in_tick_ms,
	output      logic                                peak_found,
	output      logic [atrd_pkg::RATE_W-1:0]         heart_rate,
	output      logic [atrd_pkg::LEVEL_W-1:0]        detect_threshold,
	output      logic [atrd_pkg::LEVEL_W-1:0]        signal_peak_level,
	output      logic [atrd_pkg::LEVEL_W-1:0]        noise_peak_level
);

	localparam int unsigned LW       = atrd_pkg::LEVEL_W;
	localparam int unsigned POS_W    = $clog2(INTERVAL_DEPTH);
	localparam int unsigned SUM_W    = $clog2(INTERVAL_DEPTH * 65535 + 1);
	localparam int unsigned RATE_NUM = atrd_pkg::MS_PER_MINUTE * INTERVAL_DEPTH;
	localparam int unsigned NUM_W    = $clog2(RATE_NUM + 1);
	localparam int unsigned PROD_W   = atrd_pkg::WEIGHT_W + LW;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(INTERVAL_DEPTH - 1);

	// configuration
	logic [atrd_pkg::REFR_W-1:0]   refr_q;
	logic [atrd_pkg::WEIGHT_W-1:0] weight_q;

	// detector state
	logic [LW-1:0]               older_q;
	logic [LW-1:0]               middle_q;
	logic [atrd_pkg::TICK_W-1:0] last_tick_q;
	logic [LW-1:0]               sig_q;
	logic [LW-1:0]               noise_q;
	logic [LW-1:0]               thr_q;
	logic [POS_W-1:0]            pos_q;
	logic [SUM_W-1:0]            sum_q;
	logic [atrd_pkg::RATE_W-1:0] rate_q;
	logic [INTERVAL_DEPTH-1:0]   valid_q;
	logic                        scored_q;
	logic                        hit_q;

	// per-item working registers
	logic [LW-1:0]               sample_q;
	logic [atrd_pkg::TICK_W-1:0] tick_q;
	logic [LW-1:0]               peak_q;
	logic [atrd_pkg::IV_W-1:0]   iv_q;
	logic [PROD_W-1:0]           prod_q;
	logic                        ge_q;

	// output register
	logic                        out_peak_q;
	logic [atrd_pkg::RATE_W-1:0] out_rate_q;
	logic [LW-1:0]               out_thr_q;
	logic [LW-1:0]               out_sig_q;
	logic [LW-1:0]               out_noise_q;

	logic                        is_max;
	logic [atrd_pkg::TICK_W-1:0] elapsed;
	logic                        scored_c;
	logic                        hit_c;
	logic [atrd_pkg::IV_W-1:0]   iv_c;
	logic [LW-1:0]               ema_old;
	logic [LW+2:0]               ema_t;
	logic [atrd_pkg::IV_W-1:0]   ring_rdata;
	logic [atrd_pkg::IV_W-1:0]   ring_old;
	logic [SUM_W-1:0]            sum_next;
	logic [POS_W-1:0]            pos_next;
	logic [atrd_pkg::WEIGHT_W-1:0] w_sat;
	logic                        sig_ge;
	logic [LW-1:0]               diff;
	logic [PROD_W:0]             prod_up;
	logic [LW-1:0]               thr_c;
	logic                        div_done;
	logic [NUM_W-1:0]            quotient;

	assign is_max   = (middle_q >= older_q) && (middle_q >= sample_q);
	assign elapsed  = tick_q - last_tick_q;
	assign scored_c = is_max && (elapsed >= {16'd0, refr_q});
	assign hit_c    = scored_c && (middle_q > thr_q);
	assign iv_c     = (elapsed > 32'h0000_FFFF) ? atrd_pkg::IV_MAX : elapsed[15:0];

	// level += (peak - level) / 8, as floor((peak + 7 * level) / 8)
	assign ema_old = hit_q ? sig_q : noise_q;
	assign ema_t   = {3'b000, peak_q} + {ema_old, 3'b000} - {3'b000, ema_old};

	assign ring_old = valid_q[pos_q] ? ring_rdata : '0;
	assign sum_next = sum_q - SUM_W'(ring_old) + SUM_W'(iv_q);
	assign pos_next = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;

	assign w_sat   = (weight_q > atrd_pkg::WEIGHT_FULL) ? atrd_pkg::WEIGHT_FULL : weight_q;
	assign sig_ge  = sig_q >= noise_q;
	assign diff    = sig_ge ? (sig_q - noise_q) : (noise_q - sig_q);
	// round the downward step away from noise so the blend floors
	assign prod_up = {1'b0, prod_q} + (PROD_W + 1)'(255);
	assign thr_c   = ge_q ? (noise_q + prod_q[LW+7:8]) : (noise_q - prod_up[LW+7:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_q      <= atrd_pkg::REFR_RESET;
			weight_q    <= atrd_pkg::WEIGHT_RESET;
			older_q     <= '0;
			middle_q    <= '0;
			last_tick_q <= '0;
			sig_q       <= '0;
			noise_q     <= '0;
			thr_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			rate_q      <= '0;
			valid_q     <= '0;
			scored_q    <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == atrd_pkg::CFG_REFRACTORY)) begin
				refr_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_index == atrd_pkg::CFG_WEIGHT)) begin
				weight_q <= cfg_wdata[atrd_pkg::WEIGHT_W-1:0];
			end
			if (cmd.eval) begin
				scored_q <= scored_c;
				hit_q    <= hit_c;
				older_q  <= middle_q;
				middle_q <= sample_q;
			end
			if (cmd.level && scored_q) begin
				if (hit_q) begin
					sig_q          <= ema_t[LW+2:3];
					last_tick_q    <= tick_q;
					sum_q          <= sum_next;
					pos_q          <= pos_next;
					valid_q[pos_q] <= 1'b1;
				end else begin
					noise_q <= ema_t[LW+2:3];
				end
			end
			if (cmd.thr) begin
				thr_q <= thr_c;
			end
			if (div_done) begin
				rate_q <= (quotient > NUM_W'(atrd_pkg::RATE_MAX)) ?
					atrd_pkg::RATE_MAX : quotient[atrd_pkg::RATE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			tick_q   <= in_tick_ms;
		end
		if (cmd.eval) begin
			peak_q <= middle_q;
			iv_q   <= iv_c;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(w_sat) * PROD_W'(diff);
			ge_q   <= sig_ge;
		end
		if (cmd.load_out) begin
			out_peak_q  <= hit_q;
			out_rate_q  <= rate_q;
			out_thr_q   <= thr_q;
			out_sig_q   <= sig_q;
			out_noise_q <= noise_q;
		end
	end

	atrd_ram #(
		.WIDTH (atrd_pkg::IV_W),
		.DEPTH (INTERVAL_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.level && scored_q && hit_q),
		.waddr (pos_q),
		.wdata (iv_q),
		.re    (cmd.eval),
		.raddr (pos_q),
		.rdata (ring_rdata)
	);

	atrd_div #(
		.NUM_W     (NUM_W),
		.DEN_W     (SUM_W),
		.NUMERATOR (RATE_NUM)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.scored   = scored_q;
	assign status.hit      = hit_q;
	assign status.div_done = div_done;

	assign peak_found        = out_peak_q;
	assign heart_rate        = out_rate_q;
	assign detect_threshold  = out_thr_q;
	assign signal_peak_level = out_sig_q;
	assign noise_peak_level  = out_noise_q;

endmodule
`default_nettype wire

[sv/atrd_ctrl.sv]
// Detector controller: sequences one sample through the datapath and owns the handshakes.
`default_nettype none
module atrd_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire atrd_pkg::dp_status_t   status,
	output      atrd_pkg::dp_cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_LEVEL = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_THR   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_EVAL;
			S_EVAL:  state_d = S_LEVEL;
			S_LEVEL: state_d = status.scored ? S_MUL : S_OUT;
			S_MUL:   state_d = S_THR;
			S_THR:   state_d = status.hit ? S_DIV : S_OUT;
			S_DIV:   if (status.div_done) state_d = S_OUT;
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.eval      = state_q == S_EVAL;
		cmd.level     = state_q == S_LEVEL;
		cmd.mul       = state_q == S_MUL;
		cmd.thr       = state_q == S_THR;
		cmd.div_start = (state_q == S_THR) && status.hit;
		cmd.load_out  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EVAL))
		else $error("input transfer did not start evaluation");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == S_DIV))
		else $error("rate division started outside the divide state");

	a_div_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && status.div_done) |=> (state_q == S_OUT))
		else $error("divider finished without moving to output");
`endif

endmodule
`default_nettype wire
